>>> sv/round_robin_task_picker_core_defines.svh
// Assertion helpers for the task picker checks.
// Both sample on clk_i and stay quiet while rst_ni is low.
`ifndef ROUND_ROBIN_TASK_PICKER_CORE_DEFINES_SVH
`define ROUND_ROBIN_TASK_PICKER_CORE_DEFINES_SVH

// Same-cycle implication.
`define RRTP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rrtp check failed");

// Next-cycle implication.
`define RRTP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rrtp check failed");

`endif

>>> sv/rrtp_pkg.sv
package rrtp_pkg;

  localparam int unsigned CMD_W       = 3;
  localparam int unsigned IDX_FIELD_W = 4;
  localparam int unsigned TICKS_W     = 16;
  localparam int unsigned HANDLE_W    = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK   = 3'd0,
    CMD_PICK   = 3'd1,
    CMD_WRITE  = 3'd2,
    CMD_LOOKUP = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_e;

  typedef struct packed {
    logic [CMD_W-1:0]       command;
    logic [IDX_FIELD_W-1:0] slot_index;
    logic                   slot_present;
    logic                   slot_ready;
    logic                   slot_blocked;
    logic [TICKS_W-1:0]     sleep_ticks;
    logic [HANDLE_W-1:0]    task_handle;
  } req_t;

  typedef struct packed {
    logic                   found;
    logic [IDX_FIELD_W-1:0] found_index;
    logic                   last;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;  // latch request, restart scan
    logic apply;   // commands that do not scan (write, clear, unknown)
    logic rd;      // issue slot read
    logic ev;      // evaluate read data
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_scan; // request walks the table
    logic stop;    // hit or final slot evaluated
  } dp_sts_t;

endpackage

>>> sv/rrtp_ctrl.sv
module rrtp_ctrl import rrtp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  dp_sts_t sts_i,
  output logic    busy_o,
  output logic    result_valid_o,
  output dp_cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DISP = 5'b00010,
    S_RD   = 5'b00100,
    S_EV   = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_DISP;
        end
      end
      S_DISP: begin
        if (sts_i.is_scan) begin
          state_d = S_RD;
        end else begin
          cmd_o.apply = 1'b1;
          state_d     = S_DONE;
        end
      end
      S_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_EV;
      end
      S_EV: begin
        cmd_o.ev = 1'b1;
        state_d  = sts_i.stop ? S_DONE : S_RD;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = (state_q == S_DONE);

endmodule

>>> sv/rrtp_dp.sv
module rrtp_dp import rrtp_pkg::*; #(
  parameter int unsigned NUM_SLOTS  = 16,
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  req_t    req_i,
  input  dp_cmd_t cmd_i,
  output dp_sts_t sts_o,
  output rsp_t    rsp_o
);

  localparam int unsigned IDX_W = $clog2(NUM_SLOTS);

  typedef struct packed {
    logic                  present;
    logic                  ready;
    logic                  blocked;
    logic [TIMER_BITS-1:0] timer;
    logic [HANDLE_W-1:0]   handle;
  } slot_t;

  localparam slot_t SLOT_RST = '{present: 1'b0, ready: 1'b1, blocked: 1'b0,
                                 timer: '0, handle: '0};

  slot_t                 mem [NUM_SLOTS];
  slot_t                 rd_q;
  logic                  rd_vld_q;
  logic [NUM_SLOTS-1:0]  valid_q;
  slot_t                 slot0_q;
  req_t                  req_q;
  logic [IDX_W-1:0]      cur_q, pos_q, cnt_q, where_q;
  logic                  found_q;

  logic                  is_tick, is_pick, is_write, is_lookup, is_clear;
  logic [IDX_W:0]        nxt;
  logic                  wrap, use_zero, runnable, lk_hit, hit, last_step, in_range;
  logic [IDX_W-1:0]      cand, rd_addr, mem_wa;
  slot_t                 rec, crec, mem_wd, tick_wd, wr_wd;
  logic                  tick_we, wr_we, mem_we;

  assign is_tick   = (req_q.command == CMD_TICK);
  assign is_pick   = (req_q.command == CMD_PICK);
  assign is_write  = (req_q.command == CMD_WRITE);
  assign is_lookup = (req_q.command == CMD_LOOKUP);
  assign is_clear  = (req_q.command == CMD_CLEAR);

  // never-written slots read back as their cleared value
  assign rec = rd_vld_q ? rd_q : SLOT_RST;

  // pick: step past pos, fall back to slot 0 at table end or an empty slot
  assign nxt      = {1'b0, pos_q} + (IDX_W + 1)'(1);
  assign wrap     = (nxt >= (IDX_W + 1)'(NUM_SLOTS));
  assign use_zero = wrap || !rec.present;
  assign cand     = use_zero ? '0 : nxt[IDX_W-1:0];
  assign crec     = use_zero ? slot0_q : rec;
  assign runnable = crec.present && crec.ready && !crec.blocked && (crec.timer == '0);

  assign lk_hit    = rec.present && (rec.handle == req_q.task_handle);
  assign hit       = (is_pick && runnable) || (is_lookup && lk_hit);
  assign last_step = (cnt_q == IDX_W'(NUM_SLOTS - 1));

  assign sts_o.is_scan = is_tick || is_pick || is_lookup;
  assign sts_o.stop    = hit || last_step;

  assign rd_addr = is_pick ? (wrap ? '0 : nxt[IDX_W-1:0]) : cnt_q;

  // write-back of a decremented timer during tick
  always_comb begin
    tick_wd       = rec;
    tick_wd.timer = rec.timer - TIMER_BITS'(1);
  end
  assign tick_we = cmd_i.ev && is_tick && (rec.timer != '0);

  assign in_range = (32'(req_q.slot_index) < NUM_SLOTS);
  assign wr_we    = cmd_i.apply && is_write && in_range;
  always_comb begin
    wr_wd.present = req_q.slot_present;
    wr_wd.ready   = req_q.slot_ready;
    wr_wd.blocked = req_q.slot_blocked;
    wr_wd.timer   = TIMER_BITS'(req_q.sleep_ticks);
    wr_wd.handle  = req_q.task_handle;
  end

  assign mem_we = tick_we || wr_we;
  assign mem_wa = tick_we ? cnt_q : IDX_W'(req_q.slot_index);
  assign mem_wd = tick_we ? tick_wd : wr_wd;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd_i.rd) begin
      rd_q     <= mem[rd_addr];
      rd_vld_q <= valid_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q <= req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      slot0_q <= SLOT_RST;
      cur_q   <= IDX_W'(NUM_SLOTS - 1);
      pos_q   <= '0;
      cnt_q   <= '0;
      found_q <= 1'b0;
      where_q <= '0;
    end else begin
      if (cmd_i.accept) begin
        pos_q   <= cur_q;
        cnt_q   <= '0;
        found_q <= 1'b0;
        where_q <= '0;
      end
      if (cmd_i.apply && is_clear) begin
        valid_q <= '0;
        slot0_q <= SLOT_RST;
      end
      if (mem_we) begin
        valid_q[mem_wa] <= 1'b1;
        if (mem_wa == '0) begin
          slot0_q <= mem_wd;
        end
      end
      if (cmd_i.ev) begin
        if (hit) begin
          found_q <= 1'b1;
          where_q <= is_pick ? cand : cnt_q;
          if (is_pick) begin
            cur_q <= cand;
          end
        end else begin
          cnt_q <= cnt_q + IDX_W'(1);
          if (is_pick) begin
            pos_q <= cand;
          end
        end
      end
    end
  end

  assign rsp_o.found       = found_q;
  assign rsp_o.found_index = IDX_FIELD_W'(where_q);
  assign rsp_o.last        = 1'b1;

endmodule

>>> sv/round_robin_task_picker_core.sv
// Round-robin task picker with sleep timers. A request is taken when start is
// high and busy is low; its single result appears on rsp_o for exactly one
// cycle with result_valid_o high, and there is no way to hold it off, so the
// receiver must capture it in that cycle. Write, clear and unknown commands
// pass from acceptance through the dispatch and done states back to idle.
// Tick and look-up walk the slot table one slot at a time (read, then
// evaluate), since the slots live in a single-port memory with a registered
// read: a tick always visits every slot, a look-up stops at the first matching
// slot or after the last slot when none matches. Pick next stops at the first
// runnable candidate and visits at most NUM_SLOTS candidates. No clearing
// pass is needed after reset; the block is ready at once.
module round_robin_task_picker_core import rrtp_pkg::*; #(
  parameter int unsigned NUM_SLOTS  = 16,  // 2..16
  parameter int unsigned TIMER_BITS = 16   // 8..32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  req_t req_i,
  output logic busy,
  output logic result_valid_o,
  output rsp_t rsp_o
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // Sequencer: latch request, dispatch, then read/evaluate loop for scans.
  rrtp_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .sts_i          (dp_sts),
    .busy_o         (busy),
    .result_valid_o (result_valid_o),
    .cmd_o          (dp_cmd)
  );

  // Slot memory, per-slot valid bits, slot 0 shadow, current slot and result.
  // The slot 0 shadow lets a pick step that wraps or meets an empty slot
  // evaluate slot 0 without a second memory read.
  rrtp_dp #(
    .NUM_SLOTS  (NUM_SLOTS),
    .TIMER_BITS (TIMER_BITS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (dp_cmd),
    .sts_o  (dp_sts),
    .rsp_o  (rsp_o)
  );

endmodule

>>> sv/rrtp_checker.sv
`include "round_robin_task_picker_core_defines.svh"

module rrtp_checker import rrtp_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic result_valid_o,
  input rsp_t rsp_o
);

  `RRTP_ASSERT_IMP(a_result_while_busy, result_valid_o, busy)
  `RRTP_ASSERT_NXT(a_accept_goes_busy, start && !busy, busy && !result_valid_o)
  `RRTP_ASSERT_NXT(a_result_frees, result_valid_o, !busy)
  `RRTP_ASSERT_IMP(a_last_set, result_valid_o, rsp_o.last)
  `RRTP_ASSERT_IMP(a_miss_index_zero, result_valid_o && !rsp_o.found, rsp_o.found_index == '0)

endmodule

bind round_robin_task_picker_core rrtp_checker u_rrtp_checker (.*);
